### hdl/aset_pkg.sv
// Package for the address seen set: sizes, codes, request type and hash.
// Used by every module of the block but aset_ram; depends on nothing.
package aset_pkg;

  localparam int TABLE_BITS = 12;
  localparam int SLOT_COUNT = 1 << TABLE_BITS;
  localparam int HALF       = SLOT_COUNT / 2;
  localparam int CNT_W      = TABLE_BITS + 1;
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 33;
  localparam int END_W      = ADDR_W + 1;
  localparam int PROD_W     = TABLE_BITS + 15;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic [30:0] HASH_MUL = 31'h7feb352d;

  typedef logic [TABLE_BITS-1:0] slot_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [END_W-1:0]      end_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [PROD_W-1:0]     prod_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_FORGET = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic REG_BASE     = 1'b0;
  localparam logic REG_WIN_SIZE = 1'b1;

  // classified request, front to back
  typedef struct packed {
    cmd_t  cmd;
    addr_t addr;
    size_t len;
    slot_t slot;
    logic  zero;
    logic  outside;
  } req_t;

  // xor-shift and multiply; only the low PROD_W bits matter for the slot
  function automatic prod_t hash_prod(addr_t p);
    addr_t h;
    h = p ^ (p >> 16);
    return PROD_W'(h[PROD_W-1:0] * PROD_W'(HASH_MUL));
  endfunction

  function automatic slot_t slot_of(prod_t pr);
    return pr[TABLE_BITS-1:0] ^ pr[TABLE_BITS+14:15];
  endfunction

endpackage

### hdl/aset_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module aset_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/aset_front.sv
// Front end: takes requests, checks the window and hashes the address.
// Depends on aset_pkg.
module aset_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  clearing,
  input  aset_pkg::cmd_t        in_command,
  input  aset_pkg::addr_t       in_address,
  input  aset_pkg::size_t       in_range_size,
  input  aset_pkg::addr_t       base,
  input  aset_pkg::end_t        win_end,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output aset_pkg::req_t        push_req
);

  logic             f_valid_r, f_valid_nxt;
  aset_pkg::cmd_t   f_cmd_r;
  aset_pkg::addr_t  f_addr_r;
  aset_pkg::size_t  f_len_r;
  aset_pkg::prod_t  f_prod_r;
  logic             f_zero_r, f_out_r;
  logic             accept;

  assign busy   = clearing || (f_valid_r && q_full);
  assign accept = start && !busy;
  assign push   = f_valid_r && !q_full;
  assign f_valid_nxt = accept || (f_valid_r && q_full);

  assign push_req.cmd     = f_cmd_r;
  assign push_req.addr    = f_addr_r;
  assign push_req.len     = f_len_r;
  assign push_req.slot    = aset_pkg::slot_of(f_prod_r);
  assign push_req.zero    = f_zero_r;
  assign push_req.outside = f_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    if (accept) begin
      f_cmd_r  <= in_command;
      f_addr_r <= in_address;
      f_len_r  <= in_range_size;
      f_prod_r <= aset_pkg::hash_prod(in_address);
      f_zero_r <= (in_address == '0);
      f_out_r  <= !((in_address >= base) &&
                    (aset_pkg::END_W'(in_address) < win_end));
    end
  end

endmodule

### hdl/aset_queue.sv
// Short request queue between the front end and the table engine.
// Depends on aset_pkg.
module aset_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aset_pkg::req_t  push_req,
  input  logic            pop,
  output aset_pkg::req_t  head,
  output logic            empty,
  output logic            full
);

  aset_pkg::req_t                ent_r [aset_pkg::QDEPTH];
  logic [aset_pkg::QPTR_W-1:0]   wr_r, rd_r;
  logic [aset_pkg::QPTR_W:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (aset_pkg::QPTR_W+1)'(aset_pkg::QDEPTH));
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      ent_r[wr_r] <= push_req;
    end
  end

endmodule

### hdl/aset_back.sv
// Table engine: probes, inserts and rebuilds over two table banks.
// Depends on aset_pkg and aset_ram.
module aset_back (
  input  logic            clk,
  input  logic            rst_n,
  input  aset_pkg::req_t  head,
  input  logic            q_empty,
  input  aset_pkg::addr_t base,
  input  aset_pkg::end_t  win_end,
  output logic            pop,
  output logic            clearing,
  output logic            res_valid,
  output logic            res_answer,
  output logic [1:0]      res_status
);

  typedef enum logic [2:0] {
    B_CLR, B_IDLE, B_PROBE, B_SCAN_RD, B_SCAN_DATA, B_SCAN_HASH, B_SCAN_PROBE
  } bstate_t;

  bstate_t          state_r;
  logic             cur_r;
  aset_pkg::slot_t  i_r, idx_r, idx_inc;
  aset_pkg::cnt_t   n_r, used_r;
  aset_pkg::cmd_t   cmd_r;
  aset_pkg::addr_t  addr_r, lo_r;
  aset_pkg::end_t   hi_r, end_r;
  aset_pkg::prod_t  prod_r;
  logic             keep_r;
  logic             res_valid_r, res_answer_r;
  logic [1:0]       res_status_r;

  // act is the live bank, oth the bank a rebuild fills
  logic             act_we, oth_we, b0_we, b1_we;
  aset_pkg::slot_t  act_waddr, oth_waddr, act_raddr, oth_raddr;
  aset_pkg::slot_t  b0_waddr, b1_waddr, b0_raddr, b1_raddr;
  aset_pkg::addr_t  act_wdata, oth_wdata, b0_wdata, b1_wdata;
  aset_pkg::addr_t  b0_rdata, b1_rdata, act_rdata, oth_rdata;
  logic             last_probe, last_slot;

  assign idx_inc    = idx_r + 1'b1;
  assign last_probe = (n_r == aset_pkg::CNT_W'(aset_pkg::SLOT_COUNT - 1));
  assign last_slot  = (i_r == '1);
  assign clearing   = (state_r == B_CLR);
  assign pop        = (state_r == B_IDLE) && !q_empty;
  assign res_valid  = res_valid_r;
  assign res_answer = res_answer_r;
  assign res_status = res_status_r;

  assign act_rdata = cur_r ? b1_rdata : b0_rdata;
  assign oth_rdata = cur_r ? b0_rdata : b1_rdata;

  always_comb begin
    act_we    = 1'b0;
    oth_we    = 1'b0;
    act_waddr = idx_r;
    oth_waddr = idx_r;
    act_wdata = addr_r;
    oth_wdata = addr_r;
    act_raddr = idx_inc;
    oth_raddr = idx_inc;
    unique case (state_r)
      B_CLR: begin
        act_we    = 1'b1;
        oth_we    = 1'b1;
        act_waddr = i_r;
        oth_waddr = i_r;
        act_wdata = '0;
        oth_wdata = '0;
      end
      B_IDLE: begin
        act_raddr = head.slot;
      end
      B_PROBE: begin
        if (act_rdata == '0 && cmd_r == aset_pkg::CMD_INSERT) begin
          act_we = 1'b1;
        end
      end
      B_SCAN_RD: begin
        act_raddr = i_r;
      end
      B_SCAN_DATA: begin
        // wipe the old slot behind the scan so the bank is clean next time
        act_we    = 1'b1;
        act_waddr = i_r;
        act_wdata = '0;
      end
      B_SCAN_HASH: begin
        oth_raddr = aset_pkg::slot_of(prod_r);
      end
      B_SCAN_PROBE: begin
        if (oth_rdata == '0) begin
          oth_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign b0_we    = cur_r ? oth_we    : act_we;
  assign b1_we    = cur_r ? act_we    : oth_we;
  assign b0_waddr = cur_r ? oth_waddr : act_waddr;
  assign b1_waddr = cur_r ? act_waddr : oth_waddr;
  assign b0_wdata = cur_r ? oth_wdata : act_wdata;
  assign b1_wdata = cur_r ? act_wdata : oth_wdata;
  assign b0_raddr = cur_r ? oth_raddr : act_raddr;
  assign b1_raddr = cur_r ? act_raddr : oth_raddr;

  aset_ram #(.WIDTH(aset_pkg::ADDR_W), .DEPTH(aset_pkg::SLOT_COUNT)) u_bank0 (
    .clk(clk), .we(b0_we), .waddr(b0_waddr), .wdata(b0_wdata),
    .raddr(b0_raddr), .rdata(b0_rdata)
  );

  aset_ram #(.WIDTH(aset_pkg::ADDR_W), .DEPTH(aset_pkg::SLOT_COUNT)) u_bank1 (
    .clk(clk), .we(b1_we), .waddr(b1_waddr), .wdata(b1_wdata),
    .raddr(b1_raddr), .rdata(b1_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      cur_r       <= 1'b0;
      i_r         <= '0;
      used_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= 1'b0;
      unique case (state_r)
        B_CLR: begin
          i_r <= i_r + 1'b1;
          if (last_slot) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            cmd_r  <= head.cmd;
            addr_r <= head.addr;
            idx_r  <= head.slot;
            n_r    <= '0;
            res_answer_r <= 1'b0;
            res_status_r <= aset_pkg::ST_OK;
            case (head.cmd)
              aset_pkg::CMD_INSERT: begin
                if (head.zero || head.outside) begin
                  res_valid_r  <= 1'b1;
                  res_status_r <= aset_pkg::ST_OUTSIDE;
                end else if (used_r > aset_pkg::CNT_W'(aset_pkg::HALF)) begin
                  res_valid_r  <= 1'b1;
                  res_status_r <= aset_pkg::ST_FULL;
                end else begin
                  state_r <= B_PROBE;
                end
              end
              aset_pkg::CMD_QUERY: begin
                if (head.zero) begin
                  res_valid_r <= 1'b1;
                end else begin
                  state_r <= B_PROBE;
                end
              end
              aset_pkg::CMD_FORGET: begin
                lo_r    <= head.addr;
                hi_r    <= aset_pkg::END_W'(head.addr) + aset_pkg::END_W'(head.len);
                end_r   <= win_end;
                used_r  <= '0;
                i_r     <= '0;
                state_r <= B_SCAN_RD;
              end
              default: begin
                res_valid_r <= 1'b1;
              end
            endcase
          end
        end
        B_PROBE: begin
          if (act_rdata == '0) begin
            if (cmd_r == aset_pkg::CMD_INSERT) begin
              used_r <= used_r + 1'b1;
            end
            res_valid_r  <= 1'b1;
            res_answer_r <= (cmd_r == aset_pkg::CMD_INSERT);
            state_r      <= B_IDLE;
          end else if (act_rdata == addr_r) begin
            res_valid_r  <= 1'b1;
            res_answer_r <= (cmd_r == aset_pkg::CMD_QUERY);
            state_r      <= B_IDLE;
          end else if (last_probe) begin
            res_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end else begin
            idx_r <= idx_inc;
            n_r   <= n_r + 1'b1;
          end
        end
        B_SCAN_RD: begin
          state_r <= B_SCAN_DATA;
        end
        B_SCAN_DATA: begin
          addr_r  <= act_rdata;
          prod_r  <= aset_pkg::hash_prod(act_rdata);
          keep_r  <= (act_rdata != '0) &&
                     !((act_rdata >= lo_r) && (aset_pkg::END_W'(act_rdata) < hi_r)) &&
                     (act_rdata >= base) && (aset_pkg::END_W'(act_rdata) < end_r);
          state_r <= B_SCAN_HASH;
        end
        B_SCAN_HASH: begin
          if (keep_r && used_r <= aset_pkg::CNT_W'(aset_pkg::HALF)) begin
            idx_r   <= aset_pkg::slot_of(prod_r);
            n_r     <= '0;
            state_r <= B_SCAN_PROBE;
          end else if (last_slot) begin
            cur_r        <= ~cur_r;
            res_valid_r  <= 1'b1;
            res_answer_r <= 1'b0;
            res_status_r <= aset_pkg::ST_OK;
            state_r      <= B_IDLE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= B_SCAN_RD;
          end
        end
        B_SCAN_PROBE: begin
          if (oth_rdata == '0 || oth_rdata == addr_r || last_probe) begin
            if (oth_rdata == '0) begin
              used_r <= used_r + 1'b1;
            end
            if (last_slot) begin
              cur_r        <= ~cur_r;
              res_valid_r  <= 1'b1;
              res_answer_r <= 1'b0;
              res_status_r <= aset_pkg::ST_OK;
              state_r      <= B_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= B_SCAN_RD;
            end
          end else begin
            idx_r <= idx_inc;
            n_r   <= n_r + 1'b1;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= aset_pkg::CNT_W'(aset_pkg::HALF + 1))
    else $error("occupancy above half plus one");

  a_no_result_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLR |-> !res_valid_r)
    else $error("result during clearing pass");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r != B_CLR)
    else $error("request taken while clearing");

  a_bank_flip_result: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r != $past(cur_r) |-> res_valid_r)
    else $error("bank swap without a forget result");

endmodule

### hdl/address_seen_set.sv
// Top level of the address seen set: configuration registers and wiring.
// Depends on aset_pkg, aset_front, aset_queue, aset_back.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | in_command, in_address, in_range_size   | start high, busy low
//  result   | out_answer, out_status                  | out_valid strobe, 1 cycle
//  config   | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// Insert or query: the front end registers the request with its hash product, the
// queue passes it on, and the engine probes slots on the live bank's read port.
// Forget: every slot of the old bank is read, checked and hashed, and each kept
// address is probed into the other bank, which then becomes the live bank.
// After reset a clearing pass over all 4096 slots zeroes both banks; busy is high.
// The receiver cannot stall; up to four requests may be held in flight.
module address_seen_set (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  aset_pkg::cmd_t         in_command,
  input  aset_pkg::addr_t        in_address,
  input  aset_pkg::size_t        in_range_size,
  output logic                   out_valid,
  output logic                   out_answer,
  output logic [1:0]             out_status,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  aset_pkg::addr_t        cfg_wdata
);

  aset_pkg::addr_t base_r;
  aset_pkg::size_t size_r;
  aset_pkg::end_t  win_end;
  aset_pkg::req_t  push_req, head;
  logic            push, pop, q_empty, q_full, clearing;

  assign win_end = aset_pkg::END_W'(base_r) + aset_pkg::END_W'(size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aset_pkg::REG_BASE:     base_r <= cfg_wdata;
        aset_pkg::REG_WIN_SIZE: size_r <= cfg_wdata[aset_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aset_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .clearing(clearing),
    .in_command(in_command), .in_address(in_address), .in_range_size(in_range_size),
    .base(base_r), .win_end(win_end), .q_full(q_full),
    .busy(busy), .push(push), .push_req(push_req)
  );

  aset_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_req(push_req),
    .pop(pop), .head(head), .empty(q_empty), .full(q_full)
  );

  aset_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .q_empty(q_empty),
    .base(base_r), .win_end(win_end), .pop(pop), .clearing(clearing),
    .res_valid(out_valid), .res_answer(out_answer), .res_status(out_status)
  );

endmodule

### tb/sv/testbench.sv
// Testbench for address_seen_set (depends on it and aset_pkg): directed and random
// requests checked against a behavioural model of the hashed address set in the bench.
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    aset_pkg::cmd_t  cmd;
    aset_pkg::addr_t addr;
    aset_pkg::size_t len;
  } request_t;

  typedef struct {
    logic       answer;
    logic [1:0] status;
  } reply_t;

  localparam logic [63:0] MIX_K = 64'h7feb352d;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  aset_pkg::cmd_t  in_command = aset_pkg::CMD_NONE;
  aset_pkg::addr_t in_address = '0;
  aset_pkg::size_t in_range_size = '0;
  logic            out_valid;
  logic            out_answer;
  logic [1:0]      out_status;
  logic            cfg_we = 1'b0;
  logic            cfg_index = aset_pkg::REG_BASE;
  aset_pkg::addr_t cfg_wdata = '0;

  address_seen_set dut (.*);

  always #1 clk = ~clk;

  // shadow of the set
  logic [63:0] shadow_slots [aset_pkg::SLOT_COUNT];
  logic [63:0] old_slots [aset_pkg::SLOT_COUNT];
  int unsigned members;
  logic [63:0] win_base, win_size;

  request_t        pending_reqs[$];
  reply_t          awaited_replies[$];
  aset_pkg::addr_t recent_addrs[$];
  int unsigned issued, accepted, replies, errors, forgets, fulls;
  int unsigned gap_left;
  bit          idling = 1'b1;

  function automatic int unsigned home_of(logic [63:0] p);
    logic [63:0] h;
    h = p ^ (p >> 16);
    h = h * MIX_K;
    h = h ^ (h >> 15);
    return int'(h[aset_pkg::TABLE_BITS-1:0]);
  endfunction

  // returns {status, answer}
  function automatic logic [2:0] record_addr(logic [63:0] p);
    int unsigned i;
    if (p == 0 || !(p >= win_base && p < win_base + win_size))
      return {aset_pkg::ST_OUTSIDE, 1'b0};
    if (members > aset_pkg::SLOT_COUNT / 2) return {aset_pkg::ST_FULL, 1'b0};
    i = home_of(p);
    for (int n = 0; n < aset_pkg::SLOT_COUNT; n++) begin
      if (shadow_slots[i] == 0) begin
        shadow_slots[i] = p;
        members++;
        return {aset_pkg::ST_OK, 1'b1};
      end
      if (shadow_slots[i] == p) return {aset_pkg::ST_OK, 1'b0};
      i = (i + 1) % aset_pkg::SLOT_COUNT;
    end
    return {aset_pkg::ST_OK, 1'b0};
  endfunction

  function automatic logic holds_addr(logic [63:0] p);
    int unsigned i;
    i = home_of(p);
    for (int n = 0; n < aset_pkg::SLOT_COUNT; n++) begin
      if (shadow_slots[i] == 0) return 1'b0;
      if (shadow_slots[i] == p) return 1'b1;
      i = (i + 1) % aset_pkg::SLOT_COUNT;
    end
    return 1'b0;
  endfunction

  function automatic void drop_range(logic [63:0] lo, logic [63:0] len);
    logic [63:0] hi;
    logic [2:0]  unused;
    hi = lo + len;
    old_slots = shadow_slots;
    foreach (shadow_slots[i]) shadow_slots[i] = 0;
    members = 0;
    foreach (old_slots[i])
      if (old_slots[i] != 0 && !(old_slots[i] >= lo && old_slots[i] < hi))
        unused = record_addr(old_slots[i]);
  endfunction

  function automatic reply_t predict_reply(aset_pkg::cmd_t c, aset_pkg::addr_t a,
                                           aset_pkg::size_t l);
    reply_t     r;
    logic [2:0] res;
    r.answer = 1'b0;
    r.status = aset_pkg::ST_OK;
    case (c)
      aset_pkg::CMD_INSERT: begin
        res = record_addr(64'(a));
        r.answer = res[0];
        r.status = res[2:1];
        if (res[2:1] == aset_pkg::ST_FULL) fulls++;
      end
      aset_pkg::CMD_QUERY: r.answer = (a != 0) && holds_addr(64'(a));
      aset_pkg::CMD_FORGET: begin
        drop_range(64'(a), 64'(l));
        forgets++;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: request held until taken, random idle bursts between requests while idling
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted != issued) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      gap_left <= $urandom_range(1, 12) - 1;
      start <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      request_t q;
      q = pending_reqs.pop_front();
      in_command <= q.cmd;
      in_address <= q.addr;
      in_range_size <= q.len;
      issued <= issued + 1;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check replies, then predict the request taken at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      replies++;
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply answer=%0d status=%0d", $time, out_answer, out_status);
      end else begin
        reply_t e;
        e = awaited_replies.pop_front();
        if (out_answer !== e.answer) begin
          errors++;
          $display("%0t: answer mismatch expected %0d actual %0d", $time, e.answer, out_answer);
        end
        if (out_status !== e.status) begin
          errors++;
          $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, out_status);
        end
      end
    end
    if (rst_n && start && !busy) begin
      awaited_replies.push_back(predict_reply(in_command, in_address, in_range_size));
      accepted++;
    end
  end

  task automatic add_req(aset_pkg::cmd_t c, aset_pkg::addr_t a, aset_pkg::size_t l = '0);
    request_t q;
    q.cmd = c;
    q.addr = a;
    q.len = l;
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && accepted == issued && !start
          && awaited_replies.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_window(aset_pkg::addr_t b, aset_pkg::size_t s);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= aset_pkg::REG_BASE;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_index <= aset_pkg::REG_WIN_SIZE;
    cfg_wdata <= aset_pkg::addr_t'(s);
    @(negedge clk);
    cfg_we <= 1'b0;
    win_base = 64'(b);
    win_size = 64'(s);
  endtask

  function automatic aset_pkg::addr_t rand_addr48();
    return {16'($urandom_range(0, 16'hffff)), $urandom()};
  endfunction

  function automatic aset_pkg::size_t rand_size33();
    return {1'($urandom_range(0, 1)), $urandom()};
  endfunction

  task automatic random_requests(int unsigned count);
    int unsigned     pick;
    aset_pkg::addr_t a;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 || recent_addrs.size() == 0)
        a = aset_pkg::addr_t'(win_base +
              $urandom_range(0, int'(win_size > 0 ? win_size + 8 : 8)) - 4);
      else if (pick < 80)
        a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      else if (pick < 95)
        a = rand_addr48();
      else
        a = '0;
      pick = $urandom_range(0, 199);
      if (pick < 100) begin
        add_req(aset_pkg::CMD_INSERT, a);
        recent_addrs.push_back(a);
        if (recent_addrs.size() > 64) void'(recent_addrs.pop_front());
      end else if (pick < 194) begin
        add_req(aset_pkg::CMD_QUERY, a, rand_size33());
      end else if (pick < 196) begin
        add_req(aset_pkg::CMD_FORGET, a,
                pick[0] ? aset_pkg::size_t'($urandom_range(0, 64)) : rand_size33());
      end else begin
        add_req(aset_pkg::CMD_NONE, rand_addr48(), rand_size33());
      end
    end
  endtask

  initial begin
    foreach (shadow_slots[i]) shadow_slots[i] = 0;
    members = 0;
    win_base = 0;
    win_size = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset window is empty: every insert lands outside
    add_req(aset_pkg::CMD_INSERT, 48'h1234);
    add_req(aset_pkg::CMD_QUERY, '0);
    add_req(aset_pkg::CMD_NONE, '1, '1);
    add_req(aset_pkg::CMD_FORGET, '0, '0);
    drain();

    set_window(48'h1000, 33'h10000);
    add_req(aset_pkg::CMD_INSERT, '0);
    add_req(aset_pkg::CMD_INSERT, 48'h1000);
    add_req(aset_pkg::CMD_INSERT, 48'h10fff);
    add_req(aset_pkg::CMD_INSERT, 48'h11000);
    add_req(aset_pkg::CMD_INSERT, 48'h0fff);
    add_req(aset_pkg::CMD_INSERT, 48'h1000);
    add_req(aset_pkg::CMD_QUERY, 48'h1000);
    add_req(aset_pkg::CMD_QUERY, 48'h2000);
    add_req(aset_pkg::CMD_FORGET, 48'h1000, 33'd1);
    add_req(aset_pkg::CMD_QUERY, 48'h1000);
    add_req(aset_pkg::CMD_QUERY, 48'h10fff);
    add_req(aset_pkg::CMD_FORGET, 48'h10fff, '0);
    add_req(aset_pkg::CMD_QUERY, 48'h10fff);
    drain();

    // top of the address space, window size 33'h1_0000_0000
    set_window('1, 33'h1_0000_0000);
    add_req(aset_pkg::CMD_INSERT, '1);
    add_req(aset_pkg::CMD_QUERY, '1);
    add_req(aset_pkg::CMD_QUERY, 48'h10fff);
    add_req(aset_pkg::CMD_FORGET, '0, '1);
    add_req(aset_pkg::CMD_QUERY, '1);
    drain();

    // load a few hundred members spread over a wide window
    set_window('0, 33'h1_0000_0000);
    for (int k = 1; k <= 300; k++) add_req(aset_pkg::CMD_INSERT, aset_pkg::addr_t'(k * 7919 + 3));
    add_req(aset_pkg::CMD_INSERT, aset_pkg::addr_t'(7919 + 3));
    add_req(aset_pkg::CMD_QUERY, aset_pkg::addr_t'(7919 * 5 + 3));
    drain();
    // shrink the window so the rebuild drops members, then empty the set
    set_window('0, 33'h80000);
    add_req(aset_pkg::CMD_FORGET, 48'h4000_0000, 33'h1000);
    add_req(aset_pkg::CMD_FORGET, '0, '1);
    drain();

    set_window(48'h7000_0000, 33'd2048);
    random_requests(300);
    drain();
    set_window(rand_addr48(), 33'd300);
    random_requests(300);
    drain();
    set_window(48'h1, 33'd4096);
    random_requests(300);
    drain();
    idling = 1'b0;
    set_window(48'hffff_ffff_0000, 33'd1024);
    random_requests(300);
    drain();
    repeat (50) @(posedge clk);

    $display("Checked %0d replies for %0d requests: %0d range forgets, %0d full-table refusals.",
             replies, accepted, forgets, fulls);
    if (errors == 0 && awaited_replies.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### address_seen_set.f
hdl/aset_pkg.sv
hdl/aset_ram.sv
hdl/aset_front.sv
hdl/aset_queue.sv
hdl/aset_back.sv
hdl/address_seen_set.sv
tb/sv/testbench.sv
